[hdl/glos_pkg.sv]
// Shared types and constants for the grid line-of-sight tracer.
// Used by every module under hdl except glos_ram; depends on nothing.
package glos_pkg;

  // Tile geometry and map limits.
  localparam int TILE_LOG2   = 8;
  localparam int MAP_DIM_MAX = 64;
  localparam int TILE_BITS   = 8;
  localparam int TILE        = 1 << TILE_LOG2;

  // Port widths fixed by the item fields.
  localparam int COORD_W = 16;
  localparam int TADDR_W = 12;
  localparam int TVAL_W  = 8;
  localparam int CFG_W   = 7;
  localparam int CIDX_W  = 1;

  // Derived internal widths.
  localparam int STORE_DEPTH = MAP_DIM_MAX * MAP_DIM_MAX;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int DIM_W       = ($clog2(MAP_DIM_MAX + 1) > CFG_W) ?
                               $clog2(MAP_DIM_MAX + 1) : CFG_W;
  localparam int DELTA_W     = COORD_W + 1;
  localparam int OFS_W       = DELTA_W + 1;
  localparam int CELL_W      = COORD_W - TILE_LOG2 + 2;
  localparam int LIN_W       = CELL_W + DIM_W + 1;
  localparam int PROD_W      = OFS_W + DELTA_W;
  localparam int ACC_W       = PROD_W - 1;

  localparam logic [TVAL_W-1:0] TILE_MASK = TVAL_W'((64'd1 << TILE_BITS) - 64'd1);

  // Job queue between the front end and the walker.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Command codes of an input item.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TRACE = 1'b1;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_MAP_WIDTH  = 1'b0;
  localparam logic [CIDX_W-1:0] REG_MAP_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    JOB_WRITE,
    JOB_SKIP,
    JOB_TRACE,
    JOB_EMPTY
  } glos_kind_t;

  typedef struct packed {
    glos_kind_t                 kind;
    logic [ADDR_W-1:0]          waddr;
    logic                       wall;
    logic signed [CELL_W-1:0]   col;
    logic signed [CELL_W-1:0]   row;
    logic signed [OFS_W-1:0]    xo;
    logic signed [OFS_W-1:0]    yo;
    logic signed [DELTA_W-1:0]  dx;
    logic signed [DELTA_W-1:0]  dy;
  } glos_job_t;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } glos_dims_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_STEP,
    ST_LOOK,
    ST_EMIT
  } glos_state_t;

endpackage

[hdl/glos_ram.sv]
// Generic single-port RAM with a registered read.
// Stands alone; no package is needed.
module glos_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hdl/glos_front.sv]
// Front end: decodes an input item and prepares the walker's starting values.
// Depends on glos_pkg.
module glos_front (
  input  logic                              command,
  input  logic [glos_pkg::TADDR_W-1:0]      tile_address,
  input  logic [glos_pkg::TVAL_W-1:0]       tile_value,
  input  logic signed [glos_pkg::COORD_W-1:0] start_x,
  input  logic signed [glos_pkg::COORD_W-1:0] start_y,
  input  logic signed [glos_pkg::COORD_W-1:0] end_x,
  input  logic signed [glos_pkg::COORD_W-1:0] end_y,
  output glos_pkg::glos_job_t               job
);

  logic signed [glos_pkg::DELTA_W-1:0] dx;
  logic signed [glos_pkg::DELTA_W-1:0] dy;
  logic [glos_pkg::OFS_W-1:0]          frac_x;
  logic [glos_pkg::OFS_W-1:0]          frac_y;

  assign dx = glos_pkg::DELTA_W'(end_x) - glos_pkg::DELTA_W'(start_x);
  assign dy = glos_pkg::DELTA_W'(end_y) - glos_pkg::DELTA_W'(start_y);

  assign frac_x = {{(glos_pkg::OFS_W - glos_pkg::TILE_LOG2){1'b0}},
                   start_x[glos_pkg::TILE_LOG2-1:0]};
  assign frac_y = {{(glos_pkg::OFS_W - glos_pkg::TILE_LOG2){1'b0}},
                   start_y[glos_pkg::TILE_LOG2-1:0]};

  always_comb begin
    job.waddr = glos_pkg::ADDR_W'(tile_address);
    job.wall  = (tile_value & glos_pkg::TILE_MASK) != '0;
    // Arithmetic shift rounds toward minus infinity, which is the tile index.
    job.col   = glos_pkg::CELL_W'(start_x >>> glos_pkg::TILE_LOG2);
    job.row   = glos_pkg::CELL_W'(start_y >>> glos_pkg::TILE_LOG2);
    job.xo    = (dx[glos_pkg::DELTA_W-1] ? '0 : glos_pkg::OFS_W'(glos_pkg::TILE)) - frac_x;
    job.yo    = (dy[glos_pkg::DELTA_W-1] ? '0 : glos_pkg::OFS_W'(glos_pkg::TILE)) - frac_y;
    job.dx    = dx;
    job.dy    = dy;
    if (command == glos_pkg::CMD_WRITE) begin
      if (32'(tile_address) < glos_pkg::STORE_DEPTH) begin
        job.kind = glos_pkg::JOB_WRITE;
      end else begin
        job.kind = glos_pkg::JOB_SKIP;
      end
    end else if (dx == '0 && dy == '0) begin
      job.kind = glos_pkg::JOB_EMPTY;
    end else begin
      job.kind = glos_pkg::JOB_TRACE;
    end
  end

endmodule

[hdl/glos_queue.sv]
// Small job queue that decouples the front end from the walker.
// Depends on glos_pkg.
module glos_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  glos_pkg::glos_job_t push_job,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output glos_pkg::glos_job_t head_job
);

  glos_pkg::glos_job_t           slots [glos_pkg::QUEUE_DEPTH];
  logic [glos_pkg::QPTR_W-1:0]   wr_ptr;
  logic [glos_pkg::QPTR_W-1:0]   rd_ptr;
  logic [glos_pkg::QPTR_W:0]     count;

  assign full       = count == (glos_pkg::QPTR_W + 1)'(glos_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hdl/glos_walk.sv]
// Walker: clears the tile store after reset, performs tile writes and walks traces.
// Depends on glos_pkg and glos_ram.
module glos_walk (
  input  logic                clk,
  input  logic                rst,
  input  glos_pkg::glos_dims_t dims,
  input  logic                job_valid,
  input  glos_pkg::glos_job_t job,
  output logic                pop,
  output logic                clearing,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                verdict
);

  glos_pkg::glos_state_t state;
  glos_pkg::glos_state_t state_next;

  logic [glos_pkg::ADDR_W-1:0]        clr_addr;
  logic signed [glos_pkg::DELTA_W-1:0] dx;
  logic signed [glos_pkg::DELTA_W-1:0] dy;
  logic signed [glos_pkg::CELL_W-1:0]  col;
  logic signed [glos_pkg::CELL_W-1:0]  row;
  logic signed [glos_pkg::LIN_W-1:0]   lin;
  logic signed [glos_pkg::OFS_W-1:0]   xo;
  logic signed [glos_pkg::OFS_W-1:0]   yo;
  logic [glos_pkg::ACC_W-1:0]          ax;
  logic [glos_pkg::ACC_W-1:0]          ay;
  logic                                chk;
  logic                                inr;
  logic                                result;

  logic [glos_pkg::DELTA_W-1:0] adx;
  logic [glos_pkg::DELTA_W-1:0] ady;
  logic [glos_pkg::OFS_W-1:0]   axo;
  logic [glos_pkg::OFS_W-1:0]   ayo;
  logic [glos_pkg::PROD_W-1:0]  px;
  logic [glos_pkg::PROD_W-1:0]  py;
  logic                         dx_pos;
  logic                         dy_pos;
  logic                         take_x;
  logic                         x_end;
  logic                         y_end;
  logic                         wall_hit;
  logic                         emit_ok;
  logic                         in_map;

  logic                         ram_we;
  logic [glos_pkg::ADDR_W-1:0]  ram_addr;
  logic                         ram_wdata;
  logic                         ram_rdata;

  glos_ram #(
    .WIDTH (1),
    .DEPTH (glos_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign adx = dx[glos_pkg::DELTA_W-1] ? glos_pkg::DELTA_W'(-dx) : glos_pkg::DELTA_W'(dx);
  assign ady = dy[glos_pkg::DELTA_W-1] ? glos_pkg::DELTA_W'(-dy) : glos_pkg::DELTA_W'(dy);
  assign axo = xo[glos_pkg::OFS_W-1] ? glos_pkg::OFS_W'(-xo) : glos_pkg::OFS_W'(xo);
  assign ayo = yo[glos_pkg::OFS_W-1] ? glos_pkg::OFS_W'(-yo) : glos_pkg::OFS_W'(yo);
  assign px  = axo * ady;
  assign py  = ayo * adx;

  assign dx_pos   = !dx[glos_pkg::DELTA_W-1] && dx != '0;
  assign dy_pos   = !dy[glos_pkg::DELTA_W-1] && dy != '0;
  // Ties between the two crossings go to the y axis.
  assign take_x   = ax < ay;
  assign x_end    = dx_pos ? (xo >= dx) : (xo <= dx);
  assign y_end    = dy_pos ? (yo >= dy) : (yo <= dy);
  assign wall_hit = chk && inr && ram_rdata;
  assign emit_ok  = !out_valid || out_ready;
  assign in_map   = col >= 0 && col < $signed({1'b0, dims.w}) &&
                    row >= 0 && row < $signed({1'b0, dims.h});
  assign clearing = state == glos_pkg::ST_CLEAR;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      glos_pkg::ST_CLEAR: begin
        if (clr_addr == '1) begin
          state_next = glos_pkg::ST_IDLE;
        end
      end
      glos_pkg::ST_IDLE: begin
        if (job_valid) begin
          unique case (job.kind) inside
            glos_pkg::JOB_WRITE, glos_pkg::JOB_SKIP: state_next = glos_pkg::ST_IDLE;
            glos_pkg::JOB_TRACE: state_next = glos_pkg::ST_MUL;
            glos_pkg::JOB_EMPTY: state_next = glos_pkg::ST_EMIT;
          endcase
        end
      end
      glos_pkg::ST_MUL: state_next = glos_pkg::ST_STEP;
      glos_pkg::ST_STEP: begin
        if (wall_hit || (take_x && x_end) || (!take_x && y_end)) begin
          state_next = glos_pkg::ST_EMIT;
        end else begin
          state_next = glos_pkg::ST_LOOK;
        end
      end
      glos_pkg::ST_LOOK: state_next = glos_pkg::ST_STEP;
      glos_pkg::ST_EMIT: begin
        if (emit_ok) begin
          state_next = glos_pkg::ST_IDLE;
        end
      end
      default: state_next = glos_pkg::ST_IDLE;
    endcase
  end

  // Outputs toward the queue and the tile store.
  always_comb begin
    pop       = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = glos_pkg::ADDR_W'(lin);
    ram_wdata = 1'b0;
    unique case (state) inside
      glos_pkg::ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr;
      end
      glos_pkg::ST_IDLE: begin
        pop = job_valid;
        if (job_valid && job.kind == glos_pkg::JOB_WRITE) begin
          ram_we    = 1'b1;
          ram_addr  = job.waddr;
          ram_wdata = job.wall;
        end
      end
      glos_pkg::ST_MUL, glos_pkg::ST_STEP, glos_pkg::ST_LOOK, glos_pkg::ST_EMIT: begin
        ram_we = 1'b0;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= glos_pkg::ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == glos_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == glos_pkg::ST_EMIT && emit_ok) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Walk datapath.
  always_ff @(posedge clk) begin
    case (state)
      glos_pkg::ST_IDLE: begin
        col    <= job.col;
        row    <= job.row;
        xo     <= job.xo;
        yo     <= job.yo;
        dx     <= job.dx;
        dy     <= job.dy;
        chk    <= 1'b0;
        result <= 1'b0;
      end
      glos_pkg::ST_MUL: begin
        ax  <= glos_pkg::ACC_W'(px);
        ay  <= glos_pkg::ACC_W'(py);
        lin <= glos_pkg::LIN_W'(row * $signed({1'b0, dims.w})) + glos_pkg::LIN_W'(col);
      end
      glos_pkg::ST_STEP: begin
        if (wall_hit) begin
          result <= 1'b1;
        end else if (take_x) begin
          if (!x_end) begin
            col <= dx_pos ? col + 1'b1 : col - 1'b1;
            lin <= dx_pos ? lin + 1'b1 : lin - 1'b1;
            xo  <= dx_pos ? xo + glos_pkg::OFS_W'(glos_pkg::TILE)
                          : xo - glos_pkg::OFS_W'(glos_pkg::TILE);
            ax  <= ax + (glos_pkg::ACC_W'(ady) << glos_pkg::TILE_LOG2);
          end
        end else if (!y_end) begin
          row <= dy_pos ? row + 1'b1 : row - 1'b1;
          lin <= dy_pos ? lin + glos_pkg::LIN_W'(dims.w) : lin - glos_pkg::LIN_W'(dims.w);
          yo  <= dy_pos ? yo + glos_pkg::OFS_W'(glos_pkg::TILE)
                        : yo - glos_pkg::OFS_W'(glos_pkg::TILE);
          ay  <= ay + (glos_pkg::ACC_W'(adx) << glos_pkg::TILE_LOG2);
        end
      end
      glos_pkg::ST_LOOK: begin
        inr <= in_map;
        chk <= 1'b1;
      end
      glos_pkg::ST_EMIT: begin
        if (emit_ok) begin
          verdict <= result;
        end
      end
      default: begin
        chk <= chk;
      end
    endcase
  end

  a_store_write_phase: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == glos_pkg::ST_CLEAR || state == glos_pkg::ST_IDLE))
    else $error("tile store written outside clearing or idle");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == glos_pkg::ST_IDLE && job_valid))
    else $error("queue popped outside idle");

  a_look_returns: assert property (@(posedge clk) disable iff (rst)
    state == glos_pkg::ST_LOOK |=> (state == glos_pkg::ST_STEP && chk))
    else $error("lookup not followed by a checked step");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == glos_pkg::ST_EMIT)
    else $error("result presented without an emit");

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !pop && !out_valid)
    else $error("activity during the clearing pass");

endmodule

[hdl/grid_line_of_sight_trace.sv]
// Top level of the grid line-of-sight tracer.
// Depends on glos_pkg, glos_front, glos_queue, glos_walk (and through it glos_ram).

// The block keeps a 64 by 64 tile map (zero is open, anything else is a wall) and answers
// line-of-sight queries over it. A write item stores one tile and produces no result; a trace
// item walks the tile crossings from its start point to its end point and produces one verdict:
// 0 when the path is clear, 1 when a wall tile is entered. After reset the block clears the
// tile store, one tile per cycle, and accepts no item while it does so; configuration writes
// are taken throughout. Items enter a four-deep queue, so the input side keeps accepting
// while the walker is busy or a verdict waits to be taken. The walker handles one item at a
// time: a write is done in the idle state, a zero-length trace goes straight to posting its
// verdict, and a full trace first forms the cross products by one multiply per axis, then for
// each tile crossing chooses the nearer crossing and reads the tile store, and last posts the
// verdict. Map width and height must only be changed while the block is idle; values above
// 64 behave as 64, and tiles outside the configured map count as open.
module grid_line_of_sight_trace (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [glos_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [glos_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                command,
  input  logic [glos_pkg::TADDR_W-1:0]        tile_address,
  input  logic [glos_pkg::TVAL_W-1:0]         tile_value,
  input  logic signed [glos_pkg::COORD_W-1:0] start_x,
  input  logic signed [glos_pkg::COORD_W-1:0] start_y,
  input  logic signed [glos_pkg::COORD_W-1:0] end_x,
  input  logic signed [glos_pkg::COORD_W-1:0] end_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                verdict
);

  glos_pkg::glos_dims_t dims;
  glos_pkg::glos_job_t  new_job;
  glos_pkg::glos_job_t  head_job;
  logic                 queue_full;
  logic                 head_valid;
  logic                 pop;
  logic                 clearing;
  logic                 push;
  logic [glos_pkg::DIM_W-1:0] cfg_dim;

  // Dimensions are stored already limited to the largest map the store can hold.
  assign cfg_dim = (glos_pkg::DIM_W'(cfg_data) > glos_pkg::DIM_W'(glos_pkg::MAP_DIM_MAX)) ?
                   glos_pkg::DIM_W'(glos_pkg::MAP_DIM_MAX) : glos_pkg::DIM_W'(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      dims.w <= glos_pkg::DIM_W'(glos_pkg::MAP_DIM_MAX);
      dims.h <= glos_pkg::DIM_W'(glos_pkg::MAP_DIM_MAX);
    end else if (cfg_we) begin
      unique case (cfg_index)
        glos_pkg::REG_MAP_WIDTH:  dims.w <= cfg_dim;
        glos_pkg::REG_MAP_HEIGHT: dims.h <= cfg_dim;
        default: dims <= dims;
      endcase
    end
  end

  // Items are taken whenever the queue has room and the store is not being cleared.
  assign in_ready = !queue_full && !clearing;
  assign push     = in_valid && in_ready;

  glos_front u_front (
    .command      (command),
    .tile_address (tile_address),
    .tile_value   (tile_value),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .job          (new_job)
  );

  glos_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (new_job),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  glos_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .dims      (dims),
    .job_valid (head_valid),
    .job       (head_job),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .verdict   (verdict)
  );

endmodule

[tb/tb_grid_line_of_sight_trace.sv]
// Self-checking testbench for the grid line-of-sight tracer: random and directed tile writes
// and segment traces, checked against an in-bench predictor. Depends on glos_pkg and the
// grid_line_of_sight_trace RTL.
module tb_grid_line_of_sight_trace;
  timeunit 1ns;
  timeprecision 1ps;

  // One input item as it appears on the bus. Fields a command does not use still carry
  // random values so that the block is seen to ignore them.
  typedef struct {
    logic                                 cmd;
    logic [glos_pkg::TADDR_W-1:0]         addr;
    logic [glos_pkg::TVAL_W-1:0]          value;
    logic signed [glos_pkg::COORD_W-1:0]  sx;
    logic signed [glos_pkg::COORD_W-1:0]  sy;
    logic signed [glos_pkg::COORD_W-1:0]  ex;
    logic signed [glos_pkg::COORD_W-1:0]  ey;
  } los_item_t;

  // The run goes through these map sizes in order. Zero and oversized values are included
  // on purpose: a zero dimension empties the map and anything above the maximum saturates.
  localparam int NUM_SIZES = 9;
  localparam int SETTLE_CYCLES = 64;
  // The slowest legal trace crosses about 512 tiles. With the longest gap and stall on every
  // item and the tile store clear after reset, the limit is still several times the worst case.
  localparam int CYCLE_LIMIT = 6_000_000;

  int map_widths  [NUM_SIZES] = '{64, 1, 0, 9, 127, 17, 64, 1, 40};
  int map_heights [NUM_SIZES] = '{64, 1, 17, 0, 100, 9, 1, 64, 23};
  int size_items  [NUM_SIZES] = '{280, 120, 60, 60, 200, 200, 150, 150, 160};

  logic                                  clk = 1'b0;
  logic                                  rst = 1'b1;
  logic                                  cfg_we = 1'b0;
  logic [glos_pkg::CIDX_W-1:0]           cfg_index = '0;
  logic [glos_pkg::CFG_W-1:0]            cfg_data = '0;
  logic                                  in_valid = 1'b0;
  logic                                  in_ready;
  logic                                  command = glos_pkg::CMD_WRITE;
  logic [glos_pkg::TADDR_W-1:0]          tile_address = '0;
  logic [glos_pkg::TVAL_W-1:0]           tile_value = '0;
  logic signed [glos_pkg::COORD_W-1:0]   start_x = '0;
  logic signed [glos_pkg::COORD_W-1:0]   start_y = '0;
  logic signed [glos_pkg::COORD_W-1:0]   end_x = '0;
  logic signed [glos_pkg::COORD_W-1:0]   end_y = '0;
  logic                                  out_valid;
  logic                                  out_ready = 1'b0;
  logic                                  verdict;

  grid_line_of_sight_trace DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .tile_address (tile_address),
    .tile_value   (tile_value),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .verdict      (verdict)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Predictor state: a private copy of the tile map and of the two size registers. It is
  // updated in the order items are accepted, which is the order the block applies them.
  // ---------------------------------------------------------------------------------------
  logic [glos_pkg::TVAL_W-1:0] map_copy [glos_pkg::STORE_DEPTH];
  logic [glos_pkg::CFG_W-1:0]  width_copy  = glos_pkg::CFG_W'(glos_pkg::MAP_DIM_MAX);
  logic [glos_pkg::CFG_W-1:0]  height_copy = glos_pkg::CFG_W'(glos_pkg::MAP_DIM_MAX);

  // Stimulus bookkeeping and scoreboard.
  los_item_t pending_items [$];
  los_item_t item_on_bus;
  bit        verdicts_due [$];
  int        items_issued = 0;
  int        items_taken = 0;
  int        writes_taken = 0;
  int        traces_taken = 0;
  int        blocked_seen = 0;
  int        clear_seen = 0;
  int        mismatches = 0;
  int        cycle_count = 0;

  // Dimensions above the maximum behave as the maximum.
  function automatic int dim_in_use(logic [glos_pkg::CFG_W-1:0] v);
    return (int'(v) > glos_pkg::MAP_DIM_MAX) ? glos_pkg::MAP_DIM_MAX : int'(v);
  endfunction

  // A tile outside the map in use is always open.
  function automatic bit tile_is_wall(longint col, longint row);
    longint w, h;
    w = dim_in_use(width_copy);
    h = dim_in_use(height_copy);
    if (col < 0 || col >= w || row < 0 || row >= h)
      return 1'b0;
    return map_copy[glos_pkg::ADDR_W'(row * w + col)] != '0;
  endfunction

  // Grid walk from the start point toward the end point. At each step the nearer crossing is
  // picked by comparing |x_ofs*dy| with |y_ofs*dx|; a tie goes to the y crossing. The walk
  // reports blocked on entering a wall tile and clear once the chosen crossing reaches or
  // passes the end point. The start tile itself is never tested.
  function automatic bit path_blocked(longint sx, longint sy, longint ex, longint ey);
    longint dx, dy, col, row, x_ofs, y_ofs, cross_x, cross_y;
    dx = ex - sx;
    dy = ey - sy;
    if (dx == 0 && dy == 0)
      return 1'b0;
    col = sx >>> glos_pkg::TILE_LOG2;
    row = sy >>> glos_pkg::TILE_LOG2;
    x_ofs = -(sx & longint'(glos_pkg::TILE - 1));
    y_ofs = -(sy & longint'(glos_pkg::TILE - 1));
    if (dx >= 0)
      x_ofs += glos_pkg::TILE;
    if (dy >= 0)
      y_ofs += glos_pkg::TILE;
    // A full-range segment crosses at most about 512 tiles, so the bound is never reached.
    for (int step = 0; step < 4 * glos_pkg::STORE_DEPTH; step++) begin
      cross_x = x_ofs * dy;
      cross_y = y_ofs * dx;
      if (cross_x < 0)
        cross_x = -cross_x;
      if (cross_y < 0)
        cross_y = -cross_y;
      if (cross_x < cross_y) begin
        if (dx > 0) begin
          if (sx + x_ofs >= ex)
            return 1'b0;
          col++;
        end else begin
          if (sx + x_ofs <= ex)
            return 1'b0;
          col--;
        end
        if (tile_is_wall(col, row))
          return 1'b1;
        x_ofs += (dx > 0) ? glos_pkg::TILE : -glos_pkg::TILE;
      end else begin
        if (dy > 0) begin
          if (sy + y_ofs >= ey)
            return 1'b0;
          row++;
        end else begin
          if (sy + y_ofs <= ey)
            return 1'b0;
          row--;
        end
        if (tile_is_wall(col, row))
          return 1'b1;
        y_ofs += (dy > 0) ? glos_pkg::TILE : -glos_pkg::TILE;
      end
    end
    return 1'b0;
  endfunction

  // Apply one accepted item to the predictor: writes update the map copy, traces queue the
  // verdict the block owes.
  function automatic void apply_item(los_item_t it);
    if (it.cmd == glos_pkg::CMD_WRITE) begin
      map_copy[it.addr] = it.value & glos_pkg::TILE_MASK;
      writes_taken++;
    end else begin
      verdicts_due.push_back(path_blocked(it.sx, it.sy, it.ex, it.ey));
      traces_taken++;
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Item construction.
  // ---------------------------------------------------------------------------------------
  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int clamp_coord(int v);
    if (v > 32767)
      return 32767;
    if (v < -32768)
      return -32768;
    return v;
  endfunction

  function automatic los_item_t make_write(int addr, int value);
    los_item_t it;
    it.cmd   = glos_pkg::CMD_WRITE;
    it.addr  = glos_pkg::TADDR_W'(addr);
    it.value = glos_pkg::TVAL_W'(value);
    it.sx    = glos_pkg::COORD_W'($urandom);
    it.sy    = glos_pkg::COORD_W'($urandom);
    it.ex    = glos_pkg::COORD_W'($urandom);
    it.ey    = glos_pkg::COORD_W'($urandom);
    return it;
  endfunction

  function automatic los_item_t make_trace(int sx, int sy, int ex, int ey);
    los_item_t it;
    it.cmd   = glos_pkg::CMD_TRACE;
    it.addr  = glos_pkg::TADDR_W'($urandom);
    it.value = glos_pkg::TVAL_W'($urandom);
    it.sx    = glos_pkg::COORD_W'(clamp_coord(sx));
    it.sy    = glos_pkg::COORD_W'(clamp_coord(sy));
    it.ex    = glos_pkg::COORD_W'(clamp_coord(ex));
    it.ey    = glos_pkg::COORD_W'(clamp_coord(ey));
    return it;
  endfunction

  // Random item shaped by the current map size. Most traces start on or near the map and
  // run a few tiles, so they meet walls written earlier; a smaller share is zero-length,
  // axis-aligned, or spread over the whole coordinate range.
  function automatic los_item_t random_item();
    int w, h, area, pick, span_x, span_y, reach, sx, sy, ex, ey;
    w = dim_in_use(width_copy);
    h = dim_in_use(height_copy);
    area = w * h;
    pick = $urandom_range(99);
    if (pick < 35) begin
      // Writes land mostly inside the map in use so that walls build up where traces go.
      return make_write((area > 0 && $urandom_range(9) < 6) ? int'($urandom_range(area - 1))
                                                            : int'($urandom_range(4095)),
                        ($urandom_range(2) == 0) ? 0 : int'($urandom_range(255)));
    end
    span_x = ((w < 2) ? 2 : w) * glos_pkg::TILE;
    span_y = ((h < 2) ? 2 : h) * glos_pkg::TILE;
    sx = rand_between(-glos_pkg::TILE / 2, span_x + glos_pkg::TILE / 2);
    sy = rand_between(-glos_pkg::TILE / 2, span_y + glos_pkg::TILE / 2);
    if (pick < 40)
      return make_trace(sx, sy, sx, sy);
    if (pick < 47) begin
      reach = (1 + $urandom_range(9)) * glos_pkg::TILE;
      if ($urandom_range(1) == 0)
        return make_trace(sx, sy, sx, sy + rand_between(-reach, reach));
      return make_trace(sx, sy, sx + rand_between(-reach, reach), sy);
    end
    if (pick < 53)
      return make_trace(rand_between(-32768, 32767), rand_between(-32768, 32767),
                        rand_between(-32768, 32767), rand_between(-32768, 32767));
    reach = (1 + $urandom_range(7)) * glos_pkg::TILE;
    ex = sx + rand_between(-reach, reach);
    ey = sy + rand_between(-reach, reach);
    // Snap the end point onto a tile edge now and then to hit the end-on-crossing rule.
    if ($urandom_range(3) == 0)
      ex = ex & ~(glos_pkg::TILE - 1);
    if ($urandom_range(3) == 0)
      ey = ey & ~(glos_pkg::TILE - 1);
    return make_trace(sx, sy, ex, ey);
  endfunction

  task automatic queue_item(los_item_t it);
    pending_items.push_back(it);
    items_issued++;
  endtask

  // Directed opening, run on the full 64 by 64 map. Walls go at (3,2), (63,63), (0,0) and
  // (1,0); the traces then cover zero-length segments, both directions on each axis, an end
  // point exactly on a crossing and one unit past it, a start inside a wall, segments wholly
  // outside the map, the full coordinate extremes and exact diagonal ties.
  task automatic queue_directed();
    queue_item(make_trace(300, 300, 300, 300));
    queue_item(make_write(2 * 64 + 3, 8'hFF));
    queue_item(make_write(4095, 8'h01));
    queue_item(make_write(0, 8'h80));
    queue_item(make_write(1, 8'h07));
    queue_item(make_trace(128, 640, 1408, 640));
    queue_item(make_trace(1408, 640, 128, 640));
    queue_item(make_trace(896, 100, 896, 1400));
    queue_item(make_trace(896, 1400, 896, 100));
    queue_item(make_trace(128, 100, 256, 100));
    queue_item(make_trace(128, 100, 257, 100));
    queue_item(make_trace(1000, 700, 3000, 3000));
    queue_item(make_trace(-32768, -32768, -100, -32768));
    queue_item(make_trace(-32768, -32768, 32767, 32767));
    queue_item(make_trace(32767, 32767, -32768, -32768));
    queue_item(make_trace(16383, 16383, 16000, 16383));
    queue_item(make_trace(15800, 16200, 16200, 16200));
    queue_item(make_trace(-32768, 650, 2560, 650));
    queue_item(make_trace(128, 128, 640, 640));
    queue_item(make_trace(640, 640, 128, 128));
    queue_item(make_write(1, 8'h00));
    queue_item(make_trace(128, 100, 257, 100));
    queue_item(make_write(0, 8'h00));
    queue_item(make_trace(32767, -32768, -32768, 32767));
  endtask

  // Size registers are written back to back on the plain write port while the block is idle or still clearing.
  task automatic set_map_size(int w, int h);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= glos_pkg::REG_MAP_WIDTH;
    cfg_data  <= glos_pkg::CFG_W'(w);
    @(posedge clk);
    cfg_index <= glos_pkg::REG_MAP_HEIGHT;
    cfg_data  <= glos_pkg::CFG_W'(h);
    @(posedge clk);
    cfg_we    <= 1'b0;
    width_copy  = glos_pkg::CFG_W'(w);
    height_copy = glos_pkg::CFG_W'(h);
  endtask

  // Idle means every queued item was accepted and every verdict came back. Tile writes give
  // no verdict, so a further settling wait lets the last of them drain out of the job queue.
  task automatic wait_until_idle();
    while (!(items_taken == items_issued && verdicts_due.size() == 0))
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------------------
  // Driver: presents one item at a time and holds it until it is taken. A random gap follows
  // each item; now and then gaps are switched off for a stretch so that back-to-back items
  // also fill the job queue.
  // ---------------------------------------------------------------------------------------
  int gap_left = 0;
  bit gaps_on = 1'b1;

  always @(posedge clk) begin : drive_items
    bit take_next;
    bit next_valid;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      take_next = !in_valid;
      if (in_valid && in_ready) begin
        apply_item(item_on_bus);
        items_taken++;
        take_next = 1'b1;
      end
      next_valid = in_valid && !take_next;
      if (take_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          item_on_bus = pending_items.pop_front();
          command      <= item_on_bus.cmd;
          tile_address <= item_on_bus.addr;
          tile_value   <= item_on_bus.value;
          start_x      <= item_on_bus.sx;
          start_y      <= item_on_bus.sy;
          end_x        <= item_on_bus.ex;
          end_y        <= item_on_bus.ey;
          next_valid = 1'b1;
          if ($urandom_range(39) == 0)
            gaps_on = !gaps_on;
          gap_left = gaps_on ? int'($urandom_range(15)) : 0;
        end
      end
      in_valid <= next_valid;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: takes verdicts with random stalls and compares each with the oldest prediction.
  // ---------------------------------------------------------------------------------------
  int stall_left = 0;
  bit stalls_on = 1'b1;

  task automatic flag_error(string what);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s", $realtime, what);
  endtask

  always @(posedge clk) begin : take_verdicts
    bit wanted;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          flag_error($sformatf("verdict %b arrived with no trace outstanding", verdict));
        end else begin
          wanted = verdicts_due.pop_front();
          if (verdict !== wanted)
            flag_error($sformatf("verdict mismatch: expected %b, got %b", wanted, verdict));
        end
        if (verdict === 1'b1)
          blocked_seen++;
        else
          clear_seen++;
        if ($urandom_range(39) == 0)
          stalls_on = !stalls_on;
        stall_left = stalls_on ? int'($urandom_range(15)) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0);
    end
  end

  // Hang guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sequence: reset once, then one phase per map size. The first phase opens with the
  // directed items; every phase waits for the block to go idle before the size changes.
  // ---------------------------------------------------------------------------------------
  initial begin
    foreach (map_copy[i])
      map_copy[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    for (int size = 0; size < NUM_SIZES; size++) begin
      set_map_size(map_widths[size], map_heights[size]);
      if (size == 0)
        queue_directed();
      for (int n = 0; n < size_items[size]; n++)
        queue_item(random_item());
      wait_until_idle();
    end
    $display("Ran %0d tile writes and %0d traces (%0d blocked, %0d clear) over %0d map sizes.",
             writes_taken, traces_taken, blocked_seen, clear_seen, NUM_SIZES);
    $display("Mismatches counted: %0d.", mismatches);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
